@@ rtl/core/chime_square_wave_sequencer_core_assert.svh @@
// assertion macros for the chime sequencer core
`ifndef CHIME_SQUARE_WAVE_SEQUENCER_CORE_ASSERT_SVH
`define CHIME_SQUARE_WAVE_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTH
`define CSWS_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csws assertion failed");
`define CSWS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csws assertion failed");
`else
`define CSWS_ASSERT_IMPLY(name, ante, cons)
`define CSWS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

@@ rtl/core/csws_pkg.sv @@
package csws_pkg;

    typedef enum logic [1:0] {
        CMD_PLAY    = 2'd0,
        CMD_STOP    = 2'd1,
        CMD_SERVICE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam logic signed [14:0] AMP_POS = 15'sd9000;
    localparam logic signed [14:0] AMP_NEG = -15'sd9000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // work handed from the command side to the sample side
    typedef struct packed {
        logic        clear;
        logic [31:0] inc;
    } t_job;

    function automatic logic [2:0] chime_len(input logic [2:0] ch);
        logic [2:0] len;
        case (ch)
            3'd1:    len = 3'd1;
            3'd2:    len = 3'd2;
            3'd3:    len = 3'd4;
            3'd4:    len = 3'd3;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [31:0] note_inc(input logic [2:0] ch, input logic [2:0] idx);
        logic [31:0] inc;
        case ({ch, idx})
            6'o10:   inc = 32'd171409126;
            6'o20:   inc = 32'd114401957;
            6'o21:   inc = 32'd171409126;
            6'o30:   inc = 32'd101920256;
            6'o31:   inc = 32'd128410757;
            6'o32:   inc = 32'd152708000;
            6'o33:   inc = 32'd203840511;
            6'o40:   inc = 32'd68024101;
            6'o41:   inc = 32'd50961103;
            6'o42:   inc = 32'd34011077;
            default: inc = 32'd0;
        endcase
        return inc;
    endfunction

    function automatic logic [7:0] note_dur(input logic [2:0] ch, input logic [2:0] idx);
        logic [7:0] dur;
        case ({ch, idx})
            6'o10:   dur = 8'd35;
            6'o20:   dur = 8'd60;
            6'o21:   dur = 8'd100;
            6'o30:   dur = 8'd100;
            6'o31:   dur = 8'd100;
            6'o32:   dur = 8'd100;
            6'o33:   dur = 8'd250;
            6'o40:   dur = 8'd80;
            6'o41:   dur = 8'd80;
            6'o42:   dur = 8'd160;
            default: dur = 8'd0;
        endcase
        return dur;
    endfunction

endpackage

@@ rtl/core/csws_if.sv @@
interface csws_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [2:0]  chime_select;
    logic [31:0] now_ms;

    modport source (output valid, output command, output chime_select, output now_ms,
                    input ready);
    modport sink (input valid, input command, input chime_select, input now_ms,
                  output ready);
endinterface

interface csws_smp_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] audio_sample;
    logic               last_sample;

    modport source (output valid, output audio_sample, output last_sample, input ready);
    modport sink (input valid, input audio_sample, input last_sample, output ready);
endinterface

@@ rtl/core/csws_fifo.sv @@
module csws_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  csws_pkg::t_job  i_job,
    input  logic            i_pop,
    output csws_pkg::t_job  o_job,
    output logic            o_full,
    output logic            o_empty
);
    csws_pkg::t_job                r_mem [csws_pkg::QUEUE_DEPTH];
    logic [csws_pkg::QPTR_W-1:0]   r_wr;
    logic [csws_pkg::QPTR_W-1:0]   r_rd;
    logic [csws_pkg::QPTR_W:0]     r_cnt;
    logic                          w_do_push;
    logic                          w_do_pop;

    assign o_full    = (r_cnt == (csws_pkg::QPTR_W + 1)'(csws_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ rtl/core/csws_front.sv @@
module csws_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    csws_cmd_if.sink        i_cmd,
    input  logic            i_q_full,
    output logic            o_push,
    output csws_pkg::t_job  o_job
);
    logic [2:0]  r_active, n_active;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_start, n_start;

    logic        w_accept;
    logic [2:0]  w_len;
    logic [7:0]  w_dur;
    logic [31:0] w_elapsed;
    logic [3:0]  w_next;

    assign i_cmd.ready = !i_q_full;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_idx    <= '0;
            r_start  <= '0;
        end else begin
            r_active <= n_active;
            r_idx    <= n_idx;
            r_start  <= n_start;
        end
    end

    always_comb begin
        n_active  = r_active;
        n_idx     = r_idx;
        n_start   = r_start;
        o_push    = 1'b0;
        o_job     = '{clear: 1'b1, inc: 32'd0};
        w_len     = csws_pkg::chime_len(r_active);
        w_dur     = csws_pkg::note_dur(r_active, r_idx);
        w_elapsed = i_cmd.now_ms - r_start;
        w_next    = {1'b0, r_idx} + 4'd1;
        if (w_accept) begin
            case (csws_pkg::t_cmd'(i_cmd.command))
                csws_pkg::CMD_PLAY: begin
                    n_start  = i_cmd.now_ms;
                    n_idx    = '0;
                    n_active = (csws_pkg::chime_len(i_cmd.chime_select) == 3'd0)
                               ? 3'd0 : i_cmd.chime_select;
                    o_push   = 1'b1;
                end
                csws_pkg::CMD_STOP: begin
                    n_active = '0;
                    n_idx    = '0;
                    o_push   = 1'b1;
                end
                csws_pkg::CMD_SERVICE: begin
                    if (r_active != 3'd0) begin
                        if (w_len == 3'd0 || r_idx >= w_len) begin
                            n_active = '0;
                            n_idx    = '0;
                            o_push   = 1'b1;
                        end else if (w_elapsed >= {24'd0, w_dur}) begin
                            // note time used up: step once, or finish the chime
                            if (w_next >= {1'b0, w_len}) begin
                                n_active = '0;
                                n_idx    = '0;
                                o_push   = 1'b1;
                            end else begin
                                n_idx   = w_next[2:0];
                                n_start = i_cmd.now_ms;
                                o_push  = 1'b1;
                                o_job   = '{clear: 1'b0,
                                            inc: csws_pkg::note_inc(r_active, w_next[2:0])};
                            end
                        end else begin
                            o_push = 1'b1;
                            o_job  = '{clear: 1'b0, inc: csws_pkg::note_inc(r_active, r_idx)};
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

@@ rtl/core/csws_back.sv @@
module csws_back #(
    parameter int SAMPLES_PER_SERVICE = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csws_pkg::t_job  i_job,
    input  logic            i_q_empty,
    output logic            o_pop,
    csws_smp_if.source      o_smp
);
    localparam int CNT_W = (SAMPLES_PER_SERVICE > 1) ? $clog2(SAMPLES_PER_SERVICE) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_SERVICE - 1);

    logic                r_busy, n_busy;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [31:0]         r_inc, n_inc;
    logic [31:0]         r_phase, n_phase;
    logic                r_out_valid, n_out_valid;
    logic signed [14:0]  r_out_sample, n_out_sample;
    logic                r_out_last, n_out_last;
    logic                w_can_emit;

    assign o_smp.valid        = r_out_valid;
    assign o_smp.audio_sample = r_out_sample;
    assign o_smp.last_sample  = r_out_last;
    assign w_can_emit         = !r_out_valid || o_smp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inc        <= n_inc;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_busy       = r_busy;
        n_cnt        = r_cnt;
        n_inc        = r_inc;
        n_phase      = r_phase;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        if (r_out_valid && o_smp.ready) begin
            n_out_valid = 1'b0;
        end
        if (r_busy) begin
            if (w_can_emit) begin
                n_out_valid  = 1'b1;
                n_out_sample = r_phase[31] ? csws_pkg::AMP_NEG : csws_pkg::AMP_POS;
                n_out_last   = (r_cnt == LAST_CNT);
                n_phase      = r_phase + r_inc;
                n_cnt        = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    n_busy = 1'b0;
                end
            end
        end else if (!i_q_empty) begin
            o_pop = 1'b1;
            if (i_job.clear) begin
                n_phase = '0;
            end else begin
                n_busy = 1'b1;
                n_inc  = i_job.inc;
                n_cnt  = '0;
            end
        end
    end
endmodule

@@ rtl/core/chime_square_wave_sequencer_core.sv @@
// chime sequencer: square-wave tone player driven by a command channel
// i_cmd carries play / stop / service beats (command, chime_select, now_ms);
// o_smp carries sample beats (audio_sample of +9000 or -9000, last_sample).
// play and stop give no samples; a service of a running chime gives a burst
// of SAMPLES_PER_SERVICE sample beats, the last one flagged, or none when
// the chime runs out of notes.
// a command is classified in the cycle it is taken and queued (four deep) for
// the sample generator, so commands keep flowing while a burst plays out.
// the first sample after a service beat passes the queue, the pop into the
// generator and its output register when the queue is empty; a burst then
// runs at one sample per cycle while the receiver keeps o_smp.ready high,
// from the generator's one-sample-per-cycle phase accumulator.
// reset leaves no chime playing, note 0, start time and phase at zero.
// when the receiver stalls the held beat stays on o_smp, the generator
// pauses, and once the queue fills i_cmd.ready drops.
`include "chime_square_wave_sequencer_core_assert.svh"

module chime_square_wave_sequencer_core #(
    parameter int SAMPLES_PER_SERVICE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csws_cmd_if.sink    i_cmd,
    csws_smp_if.source  o_smp
);
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    logic            w_level_ok;
    csws_pkg::t_job  w_in_job;
    csws_pkg::t_job  w_out_job;

    csws_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_in_job)
    );

    csws_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .i_pop   (w_pop),
        .o_job   (w_out_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    csws_back #(
        .SAMPLES_PER_SERVICE (SAMPLES_PER_SERVICE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (w_out_job),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .o_smp     (o_smp)
    );

    assign w_level_ok = (o_smp.audio_sample == csws_pkg::AMP_POS) ||
                        (o_smp.audio_sample == csws_pkg::AMP_NEG);

    `CSWS_ASSERT_IMPLY(a_no_overflow, w_push, !w_full)
    `CSWS_ASSERT_IMPLY(a_no_underflow, w_pop, !w_empty)
    `CSWS_ASSERT_NEXT(a_push_lands, w_push, !w_empty)
    `CSWS_ASSERT_IMPLY(a_sample_level, o_smp.valid, w_level_ok)
endmodule
